// ----- rtl/tlb_lookup_fill_fifo_lru_top_macros.svh -----
// ----------------------------------------------------------------------------
// tlb_lookup_fill_fifo_lru_top_macros: assertion macros of the TLB block
// Each macro takes a label, a clock, an active-low reset, an antecedent and
// a consequent.
// ----------------------------------------------------------------------------
`ifndef TLB_LOOKUP_FILL_FIFO_LRU_TOP_MACROS_SVH
`define TLB_LOOKUP_FILL_FIFO_LRU_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define TLBFL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("TLB assertion failed");
`define TLBFL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("TLB assertion failed");
`else
`define TLBFL_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define TLBFL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/tlbfl_pkg.sv -----
// ----------------------------------------------------------------------------
// tlbfl_pkg: shared types and constants of the TLB
// Field widths, codes and the records passed between the top level and cells.
// ----------------------------------------------------------------------------
package tlbfl_pkg;

	localparam int MAX_ENTRIES_DEF = 32;
	// Index and rank fields in the records are wide enough for 256 entries.
	localparam int IW_MAX  = 8;
	localparam int PID_W   = 16;
	localparam int PAGE_W  = 20;
	localparam int FRAME_W = 20;
	localparam int SLOT_W  = 5;
	localparam int CFG_W   = 6;

	localparam logic [CFG_W-1:0] ENTRIES_IN_USE_RESET = 6'd32;

	localparam logic FUNC_LOOKUP = 1'b0;
	localparam logic FUNC_FILL   = 1'b1;

	localparam logic CFG_ENTRIES = 1'b0;
	localparam logic CFG_POLICY  = 1'b1;

	typedef struct packed {
		logic               func;
		logic [PID_W-1:0]   pid;
		logic [PAGE_W-1:0]  page;
		logic [FRAME_W-1:0] frame;
	} item_t;

	// Running scan record that walks down the row of cells.
	typedef struct packed {
		logic               tok;
		logic               match;
		logic [IW_MAX-1:0]  match_idx;
		logic [FRAME_W-1:0] match_frame;
		logic [IW_MAX-1:0]  match_irank;
		logic [IW_MAX-1:0]  match_urank;
		logic               free;
		logic [IW_MAX-1:0]  free_idx;
		logic               vic_set;
		logic [IW_MAX-1:0]  vic_idx;
		logic [IW_MAX-1:0]  vic_irank;
		logic [IW_MAX-1:0]  vic_urank;
	} scan_rec_t;

	// Update broadcast to every cell once an item has been decided.
	typedef struct packed {
		logic              en;
		logic              fill;
		logic              was_valid;
		logic [IW_MAX-1:0] old_irank;
		logic [IW_MAX-1:0] old_urank;
	} upd_t;

endpackage

// ----- rtl/tlbfl_cell.sv -----
// ----------------------------------------------------------------------------
// tlbfl_cell: one TLB entry
// Holds key, frame and both age ranks, and folds itself into the scan record.
// ----------------------------------------------------------------------------
module tlbfl_cell #(
	parameter int MAX_ENTRIES = tlbfl_pkg::MAX_ENTRIES_DEF,
	parameter int CELL_IDX    = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  active,
	input  logic                  policy_lru,
	input  tlbfl_pkg::item_t      item,
	input  tlbfl_pkg::scan_rec_t  rec_in,
	output tlbfl_pkg::scan_rec_t  rec_out,
	input  tlbfl_pkg::upd_t       upd,
	input  logic                  sel
);
	import tlbfl_pkg::*;

	localparam int RW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam logic [RW-1:0] RANK_MAX = RW'(MAX_ENTRIES - 1);
	localparam logic [IW_MAX-1:0] MY_IDX = IW_MAX'(CELL_IDX);

	logic               valid_q;
	logic [RW-1:0]      irank_q;
	logic [RW-1:0]      urank_q;
	logic [PID_W-1:0]   pid_q;
	logic [PAGE_W-1:0]  page_q;
	logic [FRAME_W-1:0] frame_q;
	scan_rec_t          rec_q;
	scan_rec_t          rec_d;
	logic               key_hit;
	logic [IW_MAX-1:0]  my_irank;
	logic [IW_MAX-1:0]  my_urank;
	logic [IW_MAX-1:0]  my_rank;
	logic [IW_MAX-1:0]  vic_rank;
	logic               u_age;
	logic               i_age;

	assign key_hit  = valid_q && (pid_q == item.pid) && (page_q == item.page);
	assign my_irank = IW_MAX'(irank_q);
	assign my_urank = IW_MAX'(urank_q);
	assign my_rank  = policy_lru ? my_urank : my_irank;
	assign vic_rank = policy_lru ? rec_in.vic_urank : rec_in.vic_irank;

	always_comb begin
		rec_d = rec_in;
		if (rec_in.tok && active) begin
			if (key_hit && !rec_in.match) begin
				rec_d.match       = 1'b1;
				rec_d.match_idx   = MY_IDX;
				rec_d.match_frame = frame_q;
				rec_d.match_irank = my_irank;
				rec_d.match_urank = my_urank;
			end
			if (!valid_q && !rec_in.free) begin
				rec_d.free     = 1'b1;
				rec_d.free_idx = MY_IDX;
			end
			// Strictly older wins, so the lowest index keeps a tie.
			if (!rec_in.vic_set || (my_rank > vic_rank)) begin
				rec_d.vic_set   = 1'b1;
				rec_d.vic_idx   = MY_IDX;
				rec_d.vic_irank = my_irank;
				rec_d.vic_urank = my_urank;
			end
		end
	end

	assign rec_out = rec_q;

	// A valid entry ages when the touched entry was free or was older than it.
	assign u_age = (!upd.was_valid || (urank_q < RW'(upd.old_urank))) && (urank_q != RANK_MAX);
	assign i_age = (!upd.was_valid || (irank_q < RW'(upd.old_irank))) && (irank_q != RANK_MAX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q <= '0;
		end else begin
			rec_q <= rec_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			irank_q <= '0;
			urank_q <= '0;
		end else if (upd.en) begin
			if (sel) begin
				urank_q <= '0;
				if (upd.fill) begin
					irank_q <= '0;
					valid_q <= 1'b1;
				end
			end else if (valid_q) begin
				if (u_age) begin
					urank_q <= urank_q + 1'b1;
				end
				if (upd.fill && i_age) begin
					irank_q <= irank_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd.en && upd.fill && sel) begin
			pid_q   <= item.pid;
			page_q  <= item.page;
			frame_q <= item.frame;
		end
	end

endmodule

// ----- rtl/tlb_lookup_fill_fifo_lru_top.sv -----
// Flow: the block takes an item only while idle, and takes the next one only
// after the previous result has been loaded into the output register; the scan
// token walks the row of entry cells one cell per cycle.
// Reset: asynchronous, active low; all entries become free, both ranks of
// every entry clear, entries_in_use returns to 32 and the policy to FIFO.
// ----------------------------------------------------------------------------
// tlb_lookup_fill_fifo_lru_top: fully associative TLB, FIFO or LRU refill
// Lookups and fills are resolved by a scan record that passes down a row of
// entry cells, and then applied to all cells at once.
// ----------------------------------------------------------------------------
`include "tlb_lookup_fill_fifo_lru_top_macros.svh"

module tlb_lookup_fill_fifo_lru_top #(
	parameter int MAX_ENTRIES = tlbfl_pkg::MAX_ENTRIES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// Configuration write port.
	input  logic                             cfg_we,
	input  logic                             cfg_index,
	input  logic [tlbfl_pkg::CFG_W-1:0]      cfg_data,
	// Input channel.
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             func,
	input  logic [tlbfl_pkg::PID_W-1:0]      process_id,
	input  logic [tlbfl_pkg::PAGE_W-1:0]     page_number,
	input  logic [tlbfl_pkg::FRAME_W-1:0]    fill_frame,
	// Output channel.
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             hit,
	output logic [tlbfl_pkg::FRAME_W-1:0]    frame,
	output logic [tlbfl_pkg::SLOT_W-1:0]     slot,
	output logic                             done_res
);
	import tlbfl_pkg::*;

	// The controller is idle and takes items, scans, or finishes an item by
	// updating the cells and loading the output register.
	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	state_t                 state_q;
	logic [CFG_W-1:0]       entries_in_use_q;
	logic                   policy_lru_q;
	item_t                  item_q;
	logic                   start_q;
	scan_rec_t              fin_q;
	scan_rec_t              rec_w [MAX_ENTRIES+1];
	logic [MAX_ENTRIES-1:0] active;
	logic [MAX_ENTRIES-1:0] sel;
	logic [MAX_ENTRIES-1:0] toks;
	upd_t                   upd;
	logic                   in_xfer;
	logic                   out_free;
	logic                   finish_go;
	logic                   enabled;

	// Decision for the item whose scan record is in fin_q.
	logic                   res_hit;
	logic [FRAME_W-1:0]     res_frame;
	logic [IW_MAX-1:0]      res_idx;
	logic                   res_done;
	logic                   res_change;
	logic                   res_was_valid;
	logic [IW_MAX-1:0]      res_irank;
	logic [IW_MAX-1:0]      res_urank;

	logic                   out_valid_q;
	logic                   hit_q;
	logic [FRAME_W-1:0]     frame_q;
	logic [SLOT_W-1:0]      slot_q;
	logic                   done_res_q;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign finish_go = (state_q == ST_FINISH) && out_free;
	assign enabled   = (entries_in_use_q != '0);

	// Configuration registers; the user must change them only while no item is in flight; the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_in_use_q <= ENTRIES_IN_USE_RESET;
			policy_lru_q     <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ENTRIES: entries_in_use_q <= cfg_data;
				CFG_POLICY:  policy_lru_q     <= cfg_data[0];
				default:     ;
			endcase
		end
	end

	// The accepted item is held for the whole scan and the update.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_q <= '{func: func, pid: process_id, page: page_number, frame: fill_frame};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			start_q <= 1'b0;
		end else begin
			start_q <= in_xfer;
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rec_w[MAX_ENTRIES].tok) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_SCAN) && rec_w[MAX_ENTRIES].tok) begin
			fin_q <= rec_w[MAX_ENTRIES];
		end
	end

	// The scan enters the first cell with an empty record and a token. An
	// index below entries_in_use is also below MAX_ENTRIES, so comparing the
	// index with the raw register gives the clamped count for free.
	always_comb begin
		rec_w[0]     = '0;
		rec_w[0].tok = start_q;
	end

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		assign active[i] = (32'(entries_in_use_q) > i);
		assign sel[i]    = (res_idx == IW_MAX'(i));
		assign toks[i]   = rec_w[i+1].tok;

		tlbfl_cell #(
			.MAX_ENTRIES (MAX_ENTRIES),
			.CELL_IDX    (i)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.active     (active[i]),
			.policy_lru (policy_lru_q),
			.item       (item_q),
			.rec_in     (rec_w[i]),
			.rec_out    (rec_w[i+1]),
			.upd        (upd),
			.sel        (sel[i])
		);
	end

	// Resolve the item. A fill reuses the entry that already holds the key,
	// else the first free entry in use, else the oldest one by the policy.
	// With the TLB disabled every output field is zero and nothing changes.
	always_comb begin
		res_hit       = 1'b0;
		res_frame     = '0;
		res_idx       = '0;
		res_done      = 1'b0;
		res_change    = 1'b0;
		res_was_valid = 1'b1;
		res_irank     = fin_q.match_irank;
		res_urank     = fin_q.match_urank;
		if (enabled) begin
			if (item_q.func == FUNC_LOOKUP) begin
				if (fin_q.match) begin
					res_hit    = 1'b1;
					res_frame  = fin_q.match_frame;
					res_idx    = fin_q.match_idx;
					res_change = 1'b1;
				end
			end else begin
				res_frame  = item_q.frame;
				res_done   = 1'b1;
				res_change = 1'b1;
				if (fin_q.match) begin
					res_idx = fin_q.match_idx;
				end else if (fin_q.free) begin
					res_idx       = fin_q.free_idx;
					res_was_valid = 1'b0;
				end else begin
					res_idx   = fin_q.vic_idx;
					res_irank = fin_q.vic_irank;
					res_urank = fin_q.vic_urank;
				end
			end
		end
	end

	assign upd = '{
		en:        finish_go && res_change,
		fill:      (item_q.func == FUNC_FILL),
		was_valid: res_was_valid,
		old_irank: res_irank,
		old_urank: res_urank
	};

	// Output register: it holds a finished result while the next item scans.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish_go) begin
			hit_q      <= res_hit;
			frame_q    <= res_frame;
			slot_q     <= SLOT_W'(res_idx);
			done_res_q <= res_done;
		end
	end

	assign out_valid = out_valid_q;
	assign hit       = hit_q;
	assign frame     = frame_q;
	assign slot      = slot_q;
	assign done_res  = done_res_q;

	// At most one scan token is in the row of cells at any time.
	`TLBFL_ASSERT_NOW(a_one_token, clk, arst_n, 1'b1, $onehot0({start_q, toks}))
	// An update selects exactly one cell.
	`TLBFL_ASSERT_NOW(a_one_sel, clk, arst_n, upd.en, $onehot(sel))
	// While finishing, the token has left the row.
	`TLBFL_ASSERT_NOW(a_finish_clear, clk, arst_n, state_q == ST_FINISH,
		!(start_q || (|toks)))
	// Every update of the cells comes with a result transfer offered.
	`TLBFL_ASSERT_NEXT(a_upd_out, clk, arst_n, upd.en, out_valid_q)
	// A finished item always lands in the output register.
	`TLBFL_ASSERT_NEXT(a_finish_load, clk, arst_n, finish_go, out_valid_q && (state_q == ST_IDLE))

endmodule

// ----- sim/tb_tlb_lookup_fill_fifo_lru_top.sv -----
// ----------------------------------------------------------------------------
// tb_tlb_lookup_fill_fifo_lru_top: self-checking bench for the TLB block
// Drives lookups and fills, including miss-then-fill sequences, through the
// block under several sizes and both replacement policies. It predicts the
// results with its own model of the entries and their ages, or takes them as
// typed in the directed table, and compares each output transfer against the oldest one.
// ----------------------------------------------------------------------------
module tb_tlb_lookup_fill_fifo_lru_top;

	import tlbfl_pkg::*;

	localparam int SLOTS   = MAX_ENTRIES_DEF;
	localparam int AGE_CAP = SLOTS - 1;
	localparam int POOL_MAX = 40;
	localparam int DIR_ROWS = 25;
	// Cycles allowed after the last result for any stray output to show up.
	localparam int TAIL_CYCLES = MAX_ENTRIES_DEF + 8;

	// One result of the block, in the order of its output ports.
	typedef struct packed {
		logic               hit;
		logic [FRAME_W-1:0] frame;
		logic [SLOT_W-1:0]  slot;
		logic               done;
	} reply_t;

	localparam reply_t NO_REPLY = '0;

	// A row of the directed table is either one input transfer or a
	// reconfiguration of the block while it is idle.
	typedef enum logic {STEP_ITEM, STEP_CFG} step_kind_t;

	// A row either carries its result typed in, or leaves it to the model.
	localparam bit LIT_RES  = 1'b1;
	localparam bit PRED_RES = 1'b0;

	typedef struct packed {
		step_kind_t         kind;
		logic               func;
		logic [PID_W-1:0]   pid;
		logic [PAGE_W-1:0]  page;
		logic [FRAME_W-1:0] ffr;
		logic [CFG_W-1:0]   n_use;
		logic               lru;
		logic               lit;
		logic               w_hit;
		logic [FRAME_W-1:0] w_frame;
		logic [SLOT_W-1:0]  w_slot;
		logic               w_done;
	} step_t;

	// Clock, reset and every input of the block start at known values.
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = CFG_ENTRIES;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic func = FUNC_LOOKUP;
	logic [PID_W-1:0] process_id = '0;
	logic [PAGE_W-1:0] page_number = '0;
	logic [FRAME_W-1:0] fill_frame = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic hit;
	logic [FRAME_W-1:0] frame;
	logic [SLOT_W-1:0] slot;
	logic done_res;

	tlb_lookup_fill_fifo_lru_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.process_id(process_id),
		.page_number(page_number),
		.fill_frame(fill_frame),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.hit(hit),
		.frame(frame),
		.slot(slot),
		.done_res(done_res)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The bench's own picture of the TLB: contents, both age orders and the
	// two registers.
	logic               ent_valid [SLOTS];
	logic [PID_W-1:0]   ent_pid   [SLOTS];
	logic [PAGE_W-1:0]  ent_page  [SLOTS];
	logic [FRAME_W-1:0] ent_frame [SLOTS];
	logic [SLOT_W-1:0]  ins_age   [SLOTS];
	logic [SLOT_W-1:0]  use_age   [SLOTS];
	logic [CFG_W-1:0]   cfg_entries;
	logic               cfg_lru;

	// Results that the block still owes, oldest first.
	reply_t translations_due [$];

	// Idling of the two sides, in percent of cycles; changed only while idle.
	int sender_idle_pct = 0;
	int stall_pct = 0;

	int mismatches = 0;
	int results_checked = 0;
	int hits_seen = 0;
	int installs_seen = 0;
	int transfers_in = 0;
	int settings_run = 0;

	// Keys that a random phase draws from, so that lookups find entries and
	// fills collide with keys that are already held.
	logic [PID_W-1:0]  pool_pid  [POOL_MAX];
	logic [PAGE_W-1:0] pool_page [POOL_MAX];
	int pool_n;

	// Directed part. The first rows run with the reset settings: 32 entries,
	// FIFO order. Misses, the all-zero and all-ones keys, keys that match in
	// only one half, and a refill of a key already held can be read off
	// directly; the evictions, the LRU refresh on a hit, entries parked beyond
	// the count in use and the clamped size are left to the model.
	step_t dir_steps [DIR_ROWS] = '{
		'{STEP_ITEM, FUNC_LOOKUP, 16'h0000, 20'h00000, 20'h00000, 6'd0, 1'b0,
			LIT_RES, 1'b0, 20'h00000, 5'd0, 1'b0},
		'{STEP_ITEM, FUNC_LOOKUP, 16'hFFFF, 20'hFFFFF, 20'hFFFFF, 6'd0, 1'b0,
			LIT_RES, 1'b0, 20'h00000, 5'd0, 1'b0},
		'{STEP_ITEM, FUNC_FILL, 16'h0000, 20'h00000, 20'h00000, 6'd0, 1'b0,
			LIT_RES, 1'b0, 20'h00000, 5'd0, 1'b1},
		'{STEP_ITEM, FUNC_FILL, 16'hFFFF, 20'hFFFFF, 20'hFFFFF, 6'd0, 1'b0,
			LIT_RES, 1'b0, 20'hFFFFF, 5'd1, 1'b1},
		'{STEP_ITEM, FUNC_LOOKUP, 16'h0000, 20'h00000, 20'hFFFFF, 6'd0, 1'b0,
			LIT_RES, 1'b1, 20'h00000, 5'd0, 1'b0},
		'{STEP_ITEM, FUNC_LOOKUP, 16'hFFFF, 20'hFFFFF, 20'h00000, 6'd0, 1'b0,
			LIT_RES, 1'b1, 20'hFFFFF, 5'd1, 1'b0},
		'{STEP_ITEM, FUNC_LOOKUP, 16'hFFFF, 20'h00000, 20'h00000, 6'd0, 1'b0,
			LIT_RES, 1'b0, 20'h00000, 5'd0, 1'b0},
		'{STEP_ITEM, FUNC_LOOKUP, 16'h0000, 20'hFFFFF, 20'h00000, 6'd0, 1'b0,
			LIT_RES, 1'b0, 20'h00000, 5'd0, 1'b0},
		'{STEP_ITEM, FUNC_FILL, 16'hFFFF, 20'hFFFFF, 20'h5A5A5, 6'd0, 1'b0,
			LIT_RES, 1'b0, 20'h5A5A5, 5'd1, 1'b1},
		'{STEP_ITEM, FUNC_LOOKUP, 16'hFFFF, 20'hFFFFF, 20'h00000, 6'd0, 1'b0,
			PRED_RES, 1'b0, 20'h00000, 5'd0, 1'b0},
		'{STEP_CFG, FUNC_LOOKUP, 16'h0000, 20'h00000, 20'h00000, 6'd2, 1'b0,
			PRED_RES, 1'b0, 20'h00000, 5'd0, 1'b0},
		'{STEP_ITEM, FUNC_FILL, 16'h1234, 20'h00001, 20'h11111, 6'd0, 1'b0,
			PRED_RES, 1'b0, 20'h00000, 5'd0, 1'b0},
		'{STEP_ITEM, FUNC_LOOKUP, 16'h0000, 20'h00000, 20'h00000, 6'd0, 1'b0,
			PRED_RES, 1'b0, 20'h00000, 5'd0, 1'b0},
		'{STEP_CFG, FUNC_LOOKUP, 16'h0000, 20'h00000, 20'h00000, 6'd2, 1'b1,
			PRED_RES, 1'b0, 20'h00000, 5'd0, 1'b0},
		'{STEP_ITEM, FUNC_LOOKUP, 16'h1234, 20'h00001, 20'h00000, 6'd0, 1'b0,
			PRED_RES, 1'b0, 20'h00000, 5'd0, 1'b0},
		'{STEP_ITEM, FUNC_FILL, 16'h4321, 20'h00002, 20'h22222, 6'd0, 1'b0,
			PRED_RES, 1'b0, 20'h00000, 5'd0, 1'b0},
		'{STEP_CFG, FUNC_LOOKUP, 16'h0000, 20'h00000, 20'h00000, 6'd1, 1'b1,
			PRED_RES, 1'b0, 20'h00000, 5'd0, 1'b0},
		'{STEP_ITEM, FUNC_LOOKUP, 16'h4321, 20'h00002, 20'h00000, 6'd0, 1'b0,
			PRED_RES, 1'b0, 20'h00000, 5'd0, 1'b0},
		'{STEP_ITEM, FUNC_LOOKUP, 16'h1234, 20'h00001, 20'h00000, 6'd0, 1'b0,
			PRED_RES, 1'b0, 20'h00000, 5'd0, 1'b0},
		'{STEP_CFG, FUNC_LOOKUP, 16'h0000, 20'h00000, 20'h00000, 6'd0, 1'b0,
			PRED_RES, 1'b0, 20'h00000, 5'd0, 1'b0},
		'{STEP_ITEM, FUNC_LOOKUP, 16'h0000, 20'h00000, 20'h00000, 6'd0, 1'b0,
			LIT_RES, 1'b0, 20'h00000, 5'd0, 1'b0},
		'{STEP_ITEM, FUNC_FILL, 16'hABCD, 20'h12345, 20'hFFFFF, 6'd0, 1'b0,
			LIT_RES, 1'b0, 20'h00000, 5'd0, 1'b0},
		'{STEP_CFG, FUNC_LOOKUP, 16'h0000, 20'h00000, 20'h00000, 6'd63, 1'b0,
			PRED_RES, 1'b0, 20'h00000, 5'd0, 1'b0},
		'{STEP_ITEM, FUNC_FILL, 16'h0F0F, 20'hF0F0F, 20'h0F0F0, 6'd0, 1'b0,
			PRED_RES, 1'b0, 20'h00000, 5'd0, 1'b0},
		'{STEP_ITEM, FUNC_LOOKUP, 16'h0F0F, 20'hF0F0F, 20'h00000, 6'd0, 1'b0,
			PRED_RES, 1'b0, 20'h00000, 5'd0, 1'b0}
	};

	// Entry e becomes the newest in one age order. Valid entries that were
	// younger than e grow one older, or all of them when e was free, and no
	// age goes past the oldest possible value.
	function automatic void refresh_age(input bit by_use, input int e);
		bit was_valid;
		logic [SLOT_W-1:0] old_age;
		logic [SLOT_W-1:0] cur;
		was_valid = ent_valid[e];
		old_age = by_use ? use_age[e] : ins_age[e];
		for (int j = 0; j < SLOTS; j++) begin
			if (j != e && ent_valid[j]) begin
				cur = by_use ? use_age[j] : ins_age[j];
				if ((!was_valid || cur < old_age) && cur < AGE_CAP)
					cur = cur + 1'b1;
				if (by_use)
					use_age[j] = cur;
				else
					ins_age[j] = cur;
			end
		end
		if (by_use)
			use_age[e] = '0;
		else
			ins_age[e] = '0;
	endfunction

	// The first free entry among those in use, or else the oldest one in the
	// order that the policy selects; on equal ages the lowest index wins.
	function automatic int pick_victim(input int n);
		int best;
		int first_free;
		logic [SLOT_W-1:0] a_i;
		logic [SLOT_W-1:0] a_best;
		first_free = -1;
		for (int i = n - 1; i >= 0; i--)
			if (!ent_valid[i])
				first_free = i;
		if (first_free >= 0)
			return first_free;
		best = 0;
		for (int i = 1; i < n; i++) begin
			a_i = cfg_lru ? use_age[i] : ins_age[i];
			a_best = cfg_lru ? use_age[best] : ins_age[best];
			if (a_i > a_best)
				best = i;
		end
		return best;
	endfunction

	// Predicts the result of one accepted item and applies its effect on the
	// entries and their ages.
	function automatic reply_t translate_item(input item_t it);
		reply_t r;
		int n;
		int m;
		int e;
		r = '0;
		n = (cfg_entries > SLOTS) ? SLOTS : int'(cfg_entries);
		if (n == 0)
			return r;
		m = -1;
		for (int i = n - 1; i >= 0; i--)
			if (ent_valid[i] && ent_pid[i] == it.pid && ent_page[i] == it.page)
				m = i;
		if (it.func == FUNC_LOOKUP) begin
			if (m >= 0) begin
				refresh_age(1'b1, m);
				r.hit = 1'b1;
				r.frame = ent_frame[m];
				r.slot = m[SLOT_W-1:0];
			end
		end else begin
			e = (m >= 0) ? m : pick_victim(n);
			refresh_age(1'b0, e);
			refresh_age(1'b1, e);
			ent_valid[e] = 1'b1;
			ent_pid[e] = it.pid;
			ent_page[e] = it.page;
			ent_frame[e] = it.frame;
			r.frame = it.frame;
			r.slot = e[SLOT_W-1:0];
			r.done = 1'b1;
		end
		return r;
	endfunction

	// Offers one item after a random number of idle cycles and holds it until
	// the block takes it. On return the clock edge of the transfer has just
	// passed and in_valid is still high, so the next call may keep it high.
	task automatic push_item(input item_t it, input bit lit, input reply_t want);
		reply_t predicted;
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= it.func;
		process_id <= it.pid;
		page_number <= it.page;
		fill_frame <= it.frame;
		do
			@(posedge clk);
		while (in_stall);
		// The model runs on every transfer so that its state stays in step,
		// even where the row carries its own result.
		predicted = translate_item(it);
		translations_due.push_back(lit ? want : predicted);
		transfers_in++;
	endtask

	// Stops offering items and waits until every predicted result has come
	// back, which leaves the block idle.
	task automatic go_quiet();
		in_valid <= 1'b0;
		while (translations_due.size() != 0)
			@(posedge clk);
	endtask

	// Writes the size register, then the policy register; called only while idle.
	task automatic set_config(input logic [CFG_W-1:0] n_use, input logic lru);
		cfg_we <= 1'b1;
		cfg_index <= CFG_ENTRIES;
		cfg_data <= n_use;
		@(posedge clk);
		cfg_index <= CFG_POLICY;
		cfg_data <= {{(CFG_W-1){1'b0}}, lru};
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_entries = n_use;
		cfg_lru = lru;
		settings_run++;
	endtask

	// Keys for one phase: three more than twice the entries in use, but at most
	// POOL_MAX, with process ids drawn from a short list so that keys often share
	// one half with another key.
	task automatic build_pool();
		logic [PID_W-1:0] pids [4];
		int n;
		n = (cfg_entries > SLOTS) ? SLOTS : int'(cfg_entries);
		pool_n = (2 * n + 3 > POOL_MAX) ? POOL_MAX : 2 * n + 3;
		pids[0] = PID_W'($urandom_range(0, 65535));
		pids[1] = PID_W'($urandom_range(0, 65535));
		pids[2] = 16'h0000;
		pids[3] = 16'hFFFF;
		for (int i = 0; i < pool_n; i++) begin
			pool_pid[i] = pids[$urandom_range(3)];
			pool_page[i] = (i > 0 && $urandom_range(7) == 0) ? pool_page[0] :
				20'($urandom_range(0, 1048575));
		end
	endtask

	// Mostly keys from the pool; now and then a fresh key or a corner key.
	task automatic pick_key(output logic [PID_W-1:0] p, output logic [PAGE_W-1:0] g);
		int r;
		int k;
		r = $urandom_range(99);
		if (r < 80) begin
			k = $urandom_range(pool_n - 1);
			p = pool_pid[k];
			g = pool_page[k];
		end else if (r < 92) begin
			p = PID_W'($urandom_range(0, 65535));
			g = PAGE_W'($urandom_range(0, 1048575));
		end else begin
			p = $urandom_range(1) ? 16'hFFFF : 16'h0000;
			g = $urandom_range(1) ? 20'hFFFFF : 20'h00000;
		end
	endtask

	function automatic item_t make_item(input logic f, input logic [PID_W-1:0] p,
			input logic [PAGE_W-1:0] g);
		item_t it;
		it.func = f;
		it.pid = p;
		it.page = g;
		it.frame = FRAME_W'($urandom_range(0, 1048575));
		return it;
	endfunction

	// One random phase under one setting of the registers and of idling.
	// Almost half of the draws send a lookup and then a fill of the same key,
	// whether or not the lookup missed, and often a second lookup of that key.
	task automatic run_phase(input logic [CFG_W-1:0] n_use, input logic lru,
			input int idle, input int stall, input int count);
		int sent;
		int r;
		logic [PID_W-1:0] p;
		logic [PAGE_W-1:0] g;
		go_quiet();
		sender_idle_pct = idle;
		stall_pct = stall;
		set_config(n_use, lru);
		build_pool();
		sent = 0;
		while (sent < count) begin
			pick_key(p, g);
			r = $urandom_range(99);
			if (r < 45) begin
				push_item(make_item(FUNC_LOOKUP, p, g), PRED_RES, NO_REPLY);
				push_item(make_item(FUNC_FILL, p, g), PRED_RES, NO_REPLY);
				sent += 2;
				if ($urandom_range(1)) begin
					push_item(make_item(FUNC_LOOKUP, p, g), PRED_RES, NO_REPLY);
					sent++;
				end
			end else if (r < 75) begin
				push_item(make_item(FUNC_LOOKUP, p, g), PRED_RES, NO_REPLY);
				sent++;
			end else if (r < 90) begin
				push_item(make_item(FUNC_FILL, p, g), PRED_RES, NO_REPLY);
				sent++;
			end else begin
				// Noise: anything at all, unrelated to the pool.
				push_item(make_item(1'($urandom_range(1)),
					PID_W'($urandom_range(0, 65535)),
					PAGE_W'($urandom_range(0, 1048575))), PRED_RES, NO_REPLY);
				sent++;
			end
		end
	endtask

	// Output side: stalls at random and checks each result transfer against
	// the oldest prediction. Signals are sampled just after the edge, so they
	// still hold the values that the edge saw.
	always @(posedge clk) begin : check_replies
		reply_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (translations_due.size() == 0) begin
				if (mismatches < 10)
					$display("result with nothing expected: hit %0d frame %05h slot %0d done %0d",
						hit, frame, slot, done_res);
				mismatches++;
			end else begin
				want = translations_due.pop_front();
				results_checked++;
				if (want.hit)
					hits_seen++;
				if (want.done)
					installs_seen++;
				if (hit !== want.hit || frame !== want.frame || slot !== want.slot ||
						done_res !== want.done) begin
					if (mismatches < 10)
						$display("result %0d differs: expected hit %0d frame %05h",
							results_checked, want.hit, want.frame,
							" slot %0d done %0d,", want.slot, want.done,
							" got hit %0d frame %05h slot %0d done %0d",
							hit, frame, slot, done_res);
					mismatches++;
				end
			end
		end
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	initial begin : main_flow
		item_t it;
		reply_t want;
		for (int i = 0; i < SLOTS; i++) begin
			ent_valid[i] = 1'b0;
			ent_pid[i] = '0;
			ent_page[i] = '0;
			ent_frame[i] = '0;
			ins_age[i] = '0;
			use_age[i] = '0;
		end
		cfg_entries = ENTRIES_IN_USE_RESET;
		cfg_lru = 1'b0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed table, with both sides running flat out.
		for (int k = 0; k < DIR_ROWS; k++) begin
			if (dir_steps[k].kind == STEP_CFG) begin
				go_quiet();
				set_config(dir_steps[k].n_use, dir_steps[k].lru);
			end else begin
				it.func = dir_steps[k].func;
				it.pid = dir_steps[k].pid;
				it.page = dir_steps[k].page;
				it.frame = dir_steps[k].ffr;
				want.hit = dir_steps[k].w_hit;
				want.frame = dir_steps[k].w_frame;
				want.slot = dir_steps[k].w_slot;
				want.done = dir_steps[k].w_done;
				push_item(it, dir_steps[k].lit, want);
			end
		end

		// Random phases: full size and tiny sizes, the disabled TLB, the
		// clamped register value, both policies, and idling on neither side, on one or on both.
		// Each phase starts by draining the block before it is reconfigured.
		run_phase(6'd32, 1'b0, 0, 0, 200);
		run_phase(6'd4, 1'b1, 85, 0, 200);
		run_phase(6'd63, 1'b1, 0, 85, 200);
		run_phase(6'd0, 1'b0, 20, 20, 60);
		run_phase(6'd1, 1'b0, 20, 20, 120);
		run_phase(6'd8, 1'b0, 85, 0, 200);
		run_phase(6'd31, 1'b1, 0, 0, 200);
		run_phase(6'd2, 1'b1, 0, 85, 150);
		run_phase(6'd32, 1'b0, 20, 20, 120);

		// Wait for the last results, then leave room for a stray output.
		go_quiet();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d items through %0d register settings, sizes 0 to 63, FIFO and LRU.",
			transfers_in, settings_run);
		$display("Checked %0d results, %0d of them lookup hits and %0d installs.",
			results_checked, hits_seen, installs_seen);
		if (mismatches == 0)
			$display("tb_tlb_lookup_fill_fifo_lru_top passed");
		else
			$display("tb_tlb_lookup_fill_fifo_lru_top failed");
		$finish;
	end

	// A hung handshake ends the run here.
	initial begin : watchdog
		#8000000;
		$display("tb_tlb_lookup_fill_fifo_lru_top failed");
		$finish;
	end

endmodule
